FILE: rtl/core/olist_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list engine package
// Command, status and sequencer state codes shared by the list engine files.
// ----------------------------------------------------------------------------
package olist_pkg;

    typedef enum logic [3:0] {
        CMD_ADD_BACK   = 4'd0,
        CMD_ADD_FRONT  = 4'd1,
        CMD_ADD_AT     = 4'd2,
        CMD_REM_BACK   = 4'd3,
        CMD_REM_FRONT  = 4'd4,
        CMD_REM_AT     = 4'd5,
        CMD_CONTAINS   = 4'd6,
        CMD_GET        = 4'd7,
        CMD_FIND       = 4'd8,
        CMD_LENGTH     = 4'd9,
        CMD_CLEAR      = 4'd10
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHUP,
        S_SHDN,
        S_SCAN,
        S_GET,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    done;
        t_status status;
    } t_res_info;

endpackage

FILE: rtl/core/olist_mem.sv
// ----------------------------------------------------------------------------
// Ordered list entry memory
// Simple dual-port synchronous memory: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module olist_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/olist_seq.sv
// ----------------------------------------------------------------------------
// Ordered list sequencer
// Decodes each command, keeps the entry count and walks the entry memory one
// entry per cycle to shift, search or read entries.
// ----------------------------------------------------------------------------
module olist_seq #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = 8,
    parameter int CW          = 9
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [3:0]               i_command,
    input  logic [VALUE_WIDTH-1:0]   i_val,
    input  logic [8:0]               i_index,
    output logic                     o_in_stall,
    input  logic                     i_out_free,
    output olist_pkg::t_res_info     o_info,
    output logic [VALUE_WIDTH-1:0]   o_res_value,
    output logic [AW-1:0]            o_res_index,
    output logic [CW-1:0]            o_count,
    output logic                     o_rd_en,
    output logic [AW-1:0]            o_rd_addr,
    input  logic [VALUE_WIDTH-1:0]   i_rd_data,
    output logic                     o_wr_en,
    output logic [AW-1:0]            o_wr_addr,
    output logic [VALUE_WIDTH-1:0]   o_wr_data
);

    import olist_pkg::*;

    localparam int CMPW = (CW > 9) ? CW : 9;

    t_state                 r_state,     n_state;
    logic [CW-1:0]          r_count,     n_count;
    logic [VALUE_WIDTH-1:0] r_value,     n_value;
    logic [VALUE_WIDTH-1:0] r_res_value, n_res_value;
    logic [AW-1:0]          r_res_index, n_res_index;
    t_status                r_status,    n_status;
    logic [AW-1:0]          r_pos,       n_pos;
    logic [AW-1:0]          r_ptr,       n_ptr;
    logic [AW-1:0]          r_last,      n_last;
    logic [AW-1:0]          r_pa,        n_pa;
    logic                   r_pend,      n_pend;
    logic                   r_more,      n_more;

    logic [CMPW-1:0] cnt_ext;
    logic [CMPW-1:0] idx_ext;
    logic [CMPW-1:0] ins_pos;
    logic [CMPW-1:0] rem_pos;
    logic            full;
    t_cmd            cmd;

    assign cmd     = t_cmd'(i_command);
    assign cnt_ext = CMPW'(r_count);
    assign idx_ext = CMPW'(i_index);
    assign full    = (r_count == CW'(CAPACITY));

    always_comb begin
        case (cmd)
            CMD_ADD_BACK:  ins_pos = cnt_ext;
            CMD_ADD_FRONT: ins_pos = '0;
            default:       ins_pos = idx_ext;
        endcase
        case (cmd)
            CMD_REM_BACK:  rem_pos = cnt_ext - CMPW'(1);
            CMD_REM_FRONT: rem_pos = '0;
            default:       rem_pos = idx_ext;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_more  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_more  <= n_more;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value     <= n_value;
        r_res_value <= n_res_value;
        r_res_index <= n_res_index;
        r_status    <= n_status;
        r_pos       <= n_pos;
        r_ptr       <= n_ptr;
        r_last      <= n_last;
        r_pa        <= n_pa;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_value     = r_value;
        n_res_value = r_res_value;
        n_res_index = r_res_index;
        n_status    = r_status;
        n_pos       = r_pos;
        n_ptr       = r_ptr;
        n_last      = r_last;
        n_pa        = r_pa;
        n_pend      = r_pend;
        n_more      = r_more;
        o_rd_en     = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_pa;
        o_wr_data   = i_rd_data;
        o_info.done   = 1'b0;
        o_info.status = r_status;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_value = '0;
                    n_res_index = '0;
                    n_status    = ST_OK;
                    n_value     = i_val;
                    n_pend      = 1'b0;
                    n_more      = 1'b0;
                    n_state     = S_DONE;
                    case (cmd)
                        CMD_ADD_BACK, CMD_ADD_FRONT, CMD_ADD_AT: begin
                            if (ins_pos > cnt_ext) begin
                                n_status = ST_RANGE;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_pos   = AW'(ins_pos);
                                n_ptr   = AW'(cnt_ext - CMPW'(1));
                                n_more  = (ins_pos != cnt_ext);
                                n_state = S_SHUP;
                            end
                        end
                        CMD_REM_BACK, CMD_REM_FRONT, CMD_REM_AT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (rem_pos >= cnt_ext) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_pos   = AW'(rem_pos);
                                n_ptr   = AW'(rem_pos);
                                n_last  = AW'(cnt_ext - CMPW'(1));
                                n_more  = 1'b1;
                                n_state = S_SHDN;
                            end
                        end
                        CMD_CONTAINS, CMD_FIND: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_ptr   = '0;
                                n_last  = AW'(cnt_ext - CMPW'(1));
                                n_more  = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        CMD_GET: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (idx_ext >= cnt_ext) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_ptr   = AW'(idx_ext);
                                n_state = S_GET;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHUP: begin
                if (r_pend) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_pa + AW'(1);
                end
                if (r_more) begin
                    o_rd_en = 1'b1;
                    n_pend  = 1'b1;
                    n_pa    = r_ptr;
                    n_ptr   = r_ptr - AW'(1);
                    n_more  = (r_ptr != r_pos);
                end else begin
                    n_pend = 1'b0;
                end
                if (!r_pend && !r_more) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_pos;
                    o_wr_data = r_value;
                    n_count   = r_count + CW'(1);
                    n_state   = S_DONE;
                end
            end
            S_SHDN: begin
                if (r_pend) begin
                    if (r_pa == r_pos) begin
                        n_res_value = i_rd_data;
                    end else begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_pa - AW'(1);
                    end
                end
                if (r_more) begin
                    o_rd_en = 1'b1;
                    n_pend  = 1'b1;
                    n_pa    = r_ptr;
                    n_ptr   = r_ptr + AW'(1);
                    n_more  = (r_ptr != r_last);
                end else begin
                    n_pend = 1'b0;
                end
                if (!r_pend && !r_more) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (r_pend && (i_rd_data == r_value)) begin
                    n_res_index = r_pa;
                    n_pend      = 1'b0;
                    n_more      = 1'b0;
                    n_state     = S_DONE;
                end else begin
                    if (r_more) begin
                        o_rd_en = 1'b1;
                        n_pend  = 1'b1;
                        n_pa    = r_ptr;
                        n_ptr   = r_ptr + AW'(1);
                        n_more  = (r_ptr != r_last);
                    end else begin
                        n_pend = 1'b0;
                    end
                    if (!r_pend && !r_more) begin
                        n_status = ST_EMPTY;
                        n_state  = S_DONE;
                    end
                end
            end
            S_GET: begin
                if (!r_pend) begin
                    o_rd_en = 1'b1;
                    n_pend  = 1'b1;
                end else begin
                    n_res_value = i_rd_data;
                    n_pend      = 1'b0;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                o_info.done = i_out_free;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rd_addr   = r_ptr;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_value = r_res_value;
    assign o_res_index = r_res_index;
    assign o_count     = r_count;

endmodule

FILE: rtl/core/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// Ordered list engine
// Bounded ordered list of signed values with insert, remove, search, read,
// length and clear commands, one result word per command word.
// ----------------------------------------------------------------------------
// The engine takes one command word at a time and returns one result word for
// it. Inserts and removes move the entries behind the chosen position through
// the entry memory at one entry per cycle, and searches read one entry per
// cycle; an insert at the back moves nothing. The result waits in an output
// register, and the next command word is taken once the previous result is
// there. The store needs no clearing after reset.
module ordered_list_engine #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [3:0]         i_command,
    input  logic signed [31:0] i_value,
    input  logic [8:0]         i_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_result_value,
    output logic [7:0]         o_result_index,
    output logic [1:0]         o_status,
    output logic [8:0]         o_length
);

    import olist_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [VALUE_WIDTH-1:0] val_in;
    logic [31:0]            val_out;
    logic                   out_free;
    t_res_info              info;
    logic [VALUE_WIDTH-1:0] res_value;
    logic [AW-1:0]          res_index;
    logic [CW-1:0]          count;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;

    logic                   r_out_valid;
    logic [31:0]            r_result_value;
    logic [7:0]             r_result_index;
    logic [1:0]             r_status;
    logic [8:0]             r_length;

    generate
        if (VALUE_WIDTH <= 32) begin : g_narrow
            assign val_in = i_value[VALUE_WIDTH-1:0];
        end else begin : g_wide
            assign val_in = {{(VALUE_WIDTH-32){1'b0}}, i_value};
        end
        if (VALUE_WIDTH < 32) begin : g_sext
            assign val_out = {{(32-VALUE_WIDTH){res_value[VALUE_WIDTH-1]}}, res_value};
        end else begin : g_trunc
            assign val_out = res_value[31:0];
        end
    endgenerate

    assign out_free = !r_out_valid || !i_out_stall;

    olist_seq #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW),
        .CW          (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .i_val       (val_in),
        .i_index     (i_index),
        .o_in_stall  (o_in_stall),
        .i_out_free  (out_free),
        .o_info      (info),
        .o_res_value (res_value),
        .o_res_index (res_index),
        .o_count     (count),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    olist_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (info.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (info.done) begin
            r_result_value <= val_out;
            r_result_index <= 8'(res_index);
            r_status       <= info.status;
            r_length       <= 9'(count);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_result_value;
    assign o_result_index = r_result_index;
    assign o_status       = r_status;
    assign o_length       = r_length;

endmodule
